// File: rtl/core/circular_record_queue_top_macros.svh
`ifndef CIRCULAR_RECORD_QUEUE_TOP_MACROS_SVH
`define CIRCULAR_RECORD_QUEUE_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define CRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define CRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/crq_pkg.sv
package crq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_SHOW  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] rec_key;
        logic [63:0]        rec_name_tag;
        logic [7:0]         rec_age;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic [63:0]        out_name_tag;
        logic [7:0]         out_age;
        logic               has_record;
        logic               last_of_run;
        logic [3:0]         fill_level;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        name_tag;
        logic [7:0]         age;
    } record_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SHOW
    } state_t;

    typedef enum logic [2:0] {
        RES_PUSH,
        RES_FULL,
        RES_EMPTY,
        RES_CLEAR,
        RES_POP,
        RES_SHOW
    } res_kind_t;

    typedef struct packed {
        logic      load_out;
        res_kind_t out_kind;
        logic      do_push;
        logic      do_pop;
        logic      do_clear;
        logic      load_cursor;
        logic      step_cursor;
    } crq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
        logic show_last;
    } crq_stat_t;

endpackage

// File: rtl/core/crq_ctrl.sv
module crq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          req_type,
    input  crq_pkg::crq_stat_t  stat,
    output crq_pkg::crq_cmd_t   cmd
);
    import crq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.out_free && !stat.empty) begin
                    if (req_type == REQ_POP) begin
                        state_next = ST_POP;
                    end else if (req_type == REQ_SHOW) begin
                        state_next = ST_SHOW;
                    end
                end
            end
            ST_POP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHOW: begin
                if (stat.out_free && stat.show_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.out_kind    = RES_PUSH;
        case (state_reg)
            ST_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    case (req_type)
                        REQ_PUSH: begin
                            cmd.load_out = 1'b1;
                            cmd.out_kind = stat.full ? RES_FULL : RES_PUSH;
                            cmd.do_push  = !stat.full;
                        end
                        REQ_POP, REQ_SHOW: begin
                            if (stat.empty) begin
                                cmd.load_out = 1'b1;
                                cmd.out_kind = RES_EMPTY;
                            end else begin
                                cmd.load_cursor = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            cmd.load_out = 1'b1;
                            cmd.out_kind = RES_CLEAR;
                            cmd.do_clear = 1'b1;
                        end
                        default: begin
                            cmd.load_out = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = RES_POP;
                    cmd.do_pop   = 1'b1;
                end
            end
            ST_SHOW: begin
                if (stat.out_free) begin
                    cmd.load_out    = 1'b1;
                    cmd.out_kind    = RES_SHOW;
                    cmd.step_cursor = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/crq_datapath.sv
module crq_datapath #(
    parameter int DEPTH = crq_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  crq_pkg::in_item_t   s_data,
    input  crq_pkg::crq_cmd_t   cmd,
    output crq_pkg::crq_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output crq_pkg::out_item_t  m_data
);
    import crq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    record_t mem [DEPTH];

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] cursor_reg;
    logic [PTR_W-1:0] cursor_next;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] left_next;
    record_t          rd_data_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;
    logic [CNT_W-1:0] fill_cnt;
    logic [CNT_W+3:0] fill_wide;
    record_t          wr_rec;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.show_last = (left_reg == CNT_W'(1));

    assign wr_rec.key      = s_data.rec_key;
    assign wr_rec.name_tag = s_data.rec_name_tag;
    assign wr_rec.age      = s_data.rec_age;

    // record store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.do_push) begin
            mem[tail_reg] <= wr_rec;
        end
        rd_data_reg <= mem[cursor_next];
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.do_clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else if (cmd.do_push) begin
            tail_next  = advance(tail_reg);
            count_next = count_reg + 1'b1;
        end else if (cmd.do_pop) begin
            head_next  = advance(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        cursor_next = cursor_reg;
        left_next   = left_reg;
        if (cmd.load_cursor) begin
            cursor_next = head_reg;
            left_next   = count_reg;
        end else if (cmd.step_cursor) begin
            cursor_next = advance(cursor_reg);
            left_next   = left_reg - 1'b1;
        end
    end

    // result assembly
    always_comb begin
        fill_cnt                 = count_reg;
        m_data_next              = '0;
        m_data_next.last_of_run  = 1'b1;
        case (cmd.out_kind)
            RES_PUSH: begin
                fill_cnt = count_reg + 1'b1;
            end
            RES_FULL: begin
                m_data_next.status = STS_FULL;
            end
            RES_EMPTY: begin
                m_data_next.status = STS_EMPTY;
            end
            RES_CLEAR: begin
                fill_cnt = '0;
            end
            RES_POP: begin
                fill_cnt                 = count_reg - 1'b1;
                m_data_next.out_key      = rd_data_reg.key;
                m_data_next.out_name_tag = rd_data_reg.name_tag;
                m_data_next.out_age      = rd_data_reg.age;
                m_data_next.has_record   = 1'b1;
            end
            RES_SHOW: begin
                m_data_next.out_key      = rd_data_reg.key;
                m_data_next.out_name_tag = rd_data_reg.name_tag;
                m_data_next.out_age      = rd_data_reg.age;
                m_data_next.has_record   = 1'b1;
                m_data_next.last_of_run  = (left_reg == CNT_W'(1));
            end
            default: begin
                fill_cnt = count_reg;
            end
        endcase
        fill_wide              = {4'b0000, fill_cnt};
        m_data_next.fill_level = fill_wide[3:0];
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cursor_reg <= cursor_next;
        left_reg   <= left_next;
        if (cmd.load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/circular_record_queue_top.sv
// Ring-buffer queue of DEPTH records (key, 8-byte name tag, age) behind a valid/ready
// request channel and a valid/ready result channel. Push, clear, and pop or show on an
// empty queue give their one result in the cycle after the request transfer. A pop
// registers its record read first, as the store has a single registered read port. A
// show gives its held records one per cycle from that read port and stalls with the
// result channel. A request is taken once the previous request's results are all in the
// output register and that register is empty or transfers its result in the same cycle.
// No clearing pass after reset: entries are read only after being written.
module circular_record_queue_top #(
    parameter int DEPTH = crq_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  crq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output crq_pkg::out_item_t m_data
);
    import crq_pkg::*;

    crq_cmd_t  cmd;
    crq_stat_t stat;

    crq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_data.req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    crq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/core/crq_checker.sv
`include "circular_record_queue_top_macros.svh"

module crq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input crq_pkg::out_item_t m_data
);
    import crq_pkg::*;

    `CRQ_ASSERT_NEXT(a_result_holds, m_valid && !m_ready,
        m_valid && $stable(m_data), "result changed while stalled")

    `CRQ_ASSERT_NOW(a_record_only_ok, m_valid && m_data.has_record,
        m_data.status == STS_OK, "record carried with error status")

    `CRQ_ASSERT_NOW(a_no_record_zero, m_valid && !m_data.has_record,
        m_data.out_key == '0 && m_data.out_name_tag == '0 && m_data.out_age == '0
        && m_data.last_of_run, "stray record fields")

    `CRQ_ASSERT_NOW(a_empty_no_fill, m_valid && m_data.status == STS_EMPTY,
        m_data.fill_level == '0 && !m_data.has_record, "empty status with entries")

endmodule

bind circular_record_queue_top crq_checker u_crq_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import crq_pkg::*;

    localparam int QDEPTH         = DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 2 * QDEPTH + 4;
    localparam int MAX_REPORTS    = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    logic signed [31:0] rec_keys  [QDEPTH];
    logic [63:0]        rec_names [QDEPTH];
    logic [7:0]         rec_ages  [QDEPTH];
    int                 rec_head  = 0;
    int                 rec_tail  = 0;
    int                 rec_count = 0;
    out_item_t          pending_results [$];

    circular_record_queue_top #(
        .DEPTH(QDEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic out_item_t record_result(logic [1:0] status, int slot, logic last);
        out_item_t r;
        r = '0;
        r.status = status;
        if (slot >= 0) begin
            r.out_key      = rec_keys[slot];
            r.out_name_tag = rec_names[slot];
            r.out_age      = rec_ages[slot];
            r.has_record   = 1'b1;
        end
        r.last_of_run = last;
        r.fill_level  = 4'(rec_count);
        return r;
    endfunction

    task automatic predict_queue_op(input in_item_t item);
        int slot;
        case (item.req_type)
            REQ_PUSH: begin
                if (rec_count >= QDEPTH) begin
                    pending_results.push_back(record_result(STS_FULL, -1, 1'b1));
                end else begin
                    rec_keys[rec_tail]  = item.rec_key;
                    rec_names[rec_tail] = item.rec_name_tag;
                    rec_ages[rec_tail]  = item.rec_age;
                    rec_tail  = (rec_tail + 1) % QDEPTH;
                    rec_count = rec_count + 1;
                    pending_results.push_back(record_result(STS_OK, -1, 1'b1));
                end
            end
            REQ_POP: begin
                if (rec_count == 0) begin
                    pending_results.push_back(record_result(STS_EMPTY, -1, 1'b1));
                end else begin
                    slot      = rec_head;
                    rec_head  = (rec_head + 1) % QDEPTH;
                    rec_count = rec_count - 1;
                    pending_results.push_back(record_result(STS_OK, slot, 1'b1));
                end
            end
            REQ_SHOW: begin
                if (rec_count == 0) begin
                    pending_results.push_back(record_result(STS_EMPTY, -1, 1'b1));
                end else begin
                    for (int i = 0; i < rec_count; i++) begin
                        pending_results.push_back(record_result(STS_OK,
                            (rec_head + i) % QDEPTH, i == rec_count - 1));
                    end
                end
            end
            REQ_CLEAR: begin
                rec_head  = 0;
                rec_tail  = 0;
                rec_count = 0;
                pending_results.push_back(record_result(STS_OK, -1, 1'b1));
            end
        endcase
    endtask

    task automatic print_result(input string tag, input out_item_t r);
        $display("  %s status=%0d key=%h name=%h age=%0d rec=%b last=%b fill=%0d",
                 tag, r.status, r.out_key, r.out_name_tag, r.out_age,
                 r.has_record, r.last_of_run, r.fill_level);
    endtask

    always @(posedge aclk) begin : check_results
        out_item_t want;
        logic      differs;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: result transfer with nothing pending", $time);
                    print_result("actual  ", m_data);
                end
            end else begin
                want = pending_results.pop_front();
                differs = (m_data.status !== want.status)
                       || (m_data.out_key !== want.out_key)
                       || (m_data.out_name_tag !== want.out_name_tag)
                       || (m_data.out_age !== want.out_age)
                       || (m_data.has_record !== want.has_record)
                       || (m_data.last_of_run !== want.last_of_run)
                       || (m_data.fill_level !== want.fill_level);
                if (differs) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: result mismatch", $time);
                        print_result("expected", want);
                        print_result("actual  ", m_data);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_req(input in_item_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_queue_op(item);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_age();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // payload is random even where the request ignores it
    function automatic in_item_t make_op(logic [1:0] req);
        in_item_t r;
        r.req_type     = req;
        r.rec_key      = $urandom;
        r.rec_name_tag = {$urandom, $urandom};
        r.rec_age      = random_age();
        return r;
    endfunction

    function automatic in_item_t make_push(logic signed [31:0] key, logic [63:0] name,
                                           logic [7:0] age);
        in_item_t r;
        r.req_type     = REQ_PUSH;
        r.rec_key      = key;
        r.rec_name_tag = name;
        r.rec_age      = age;
        return r;
    endfunction

    function automatic in_item_t random_req();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) return make_op(REQ_PUSH);
        if (pick < 78) return make_op(REQ_POP);
        if (pick < 93) return make_op(REQ_SHOW);
        return make_op(REQ_CLEAR);
    endfunction

    task automatic test_directed();
        send_req(make_op(REQ_POP));
        send_req(make_op(REQ_SHOW));
        send_req(make_push(32'sh8000_0000, 64'h0, 8'h00));
        send_req(make_push(32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF));
        send_req(make_push(-32'sd1, 64'h5555_5555_5555_5555, 8'h55));
        send_req(make_push(32'sd0, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA));
        repeat (QDEPTH - 4) send_req(make_op(REQ_PUSH));
        // push into a full queue
        send_req(make_op(REQ_PUSH));
        send_req(make_op(REQ_SHOW));
        repeat (3) send_req(make_op(REQ_POP));
        // pointers wrap
        repeat (2) send_req(make_op(REQ_PUSH));
        send_req(make_op(REQ_SHOW));
        send_req(make_op(REQ_CLEAR));
        send_req(make_op(REQ_SHOW));
        send_req(make_op(REQ_POP));
        send_req(make_op(REQ_PUSH));
        send_req(make_op(REQ_CLEAR));
        wait_until_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        repeat (n_items) send_req(random_req());
    endtask

    task automatic test_pause_until_drained(input int n_items);
        test_random_traffic(n_items / 2);
        wait_until_drained();
        test_random_traffic(n_items - n_items / 2);
    endtask

    initial begin : run
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(120);

        send_idle_pct  = 83;
        recv_stall_pct = 0;
        test_random_traffic(110);

        send_idle_pct  = 0;
        recv_stall_pct = 83;
        test_pause_until_drained(110);

        send_idle_pct  = 25;
        recv_stall_pct = 25;
        test_random_traffic(120);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/crq_pkg.sv
rtl/core/crq_ctrl.sv
rtl/core/crq_datapath.sv
rtl/core/circular_record_queue_top.sv
rtl/core/crq_checker.sv
tb/tb_top.sv
